// ===== src/sit_block_encrypt_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SIT_BLOCK_ENCRYPT_TOP_DEFINES_SVH
`define SIT_BLOCK_ENCRYPT_TOP_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define SBE_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sbe property failed");

// Check that a condition implies a sequence starting in the same cycle.
`define SBE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("sbe implication failed");

`endif

// ===== src/sbe_pkg.sv =====
package sbe_pkg;

    localparam int NUM_ROUNDS = 5;
    localparam int WORD_W     = 16;
    localparam int BLOCK_W    = 64;
    localparam int KEY_IDX_W  = 3;

    typedef logic [WORD_W-1:0]                  word_t;
    typedef logic [BLOCK_W-1:0]                 block_t;
    typedef logic [NUM_ROUNDS-1:0][WORD_W-1:0]  key_set_t;
    typedef logic [3:0]                         nibble_t;

    // Register indexes of the configuration port
    typedef enum logic [KEY_IDX_W-1:0] {
        REG_KEY_ONE   = 3'd0,
        REG_KEY_TWO   = 3'd1,
        REG_KEY_THREE = 3'd2,
        REG_KEY_FOUR  = 3'd3,
        REG_KEY_FIVE  = 3'd4
    } reg_index_t;

    // Stage control that travels alongside the data
    typedef struct packed {
        logic valid;
    } stage_ctrl_t;

    localparam nibble_t SBOX_P [16] = '{
        4'd3, 4'd15, 4'd14, 4'd0, 4'd5, 4'd4, 4'd11, 4'd12,
        4'd13, 4'd10, 4'd9, 4'd6, 4'd7, 4'd8, 4'd2, 4'd1
    };

    localparam nibble_t SBOX_Q [16] = '{
        4'd9, 4'd14, 4'd5, 4'd6, 4'd10, 4'd2, 4'd3, 4'd12,
        4'd15, 4'd0, 4'd4, 4'd13, 4'd7, 4'd11, 4'd1, 4'd8
    };

    function automatic nibble_t sp(input nibble_t v);
        return SBOX_P[v];
    endfunction

    function automatic nibble_t sq(input nibble_t v);
        return SBOX_Q[v];
    endfunction

    // Three S-box layers with the nibble halves crossed between layers
    function automatic word_t mix_f(input word_t w);
        nibble_t a0, b0, c0, d0;
        nibble_t a1, b1, c1, d1;
        nibble_t a2, b2, c2, d2;
        a0 = sp(w[15:12]);
        b0 = sq(w[11:8]);
        c0 = sp(w[7:4]);
        d0 = sq(w[3:0]);

        a1 = sq({a0[3:2], b0[3:2]});
        b1 = sp({a0[1:0], c0[3:2]});
        c1 = sq({b0[1:0], d0[3:2]});
        d1 = sp({c0[1:0], d0[1:0]});

        a2 = sp({a1[3:2], b1[3:2]});
        b2 = sq({a1[1:0], c1[3:2]});
        c2 = sp({b1[1:0], d1[3:2]});
        d2 = sq({c1[1:0], d1[1:0]});
        return {a2, b2, c2, d2};
    endfunction

endpackage

// ===== src/sbe_key_regs.sv =====
module sbe_key_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sbe_pkg::KEY_IDX_W-1:0]      cfg_index,
    input  logic [sbe_pkg::WORD_W-1:0]         cfg_data,
    output sbe_pkg::key_set_t                  keys
);

    sbe_pkg::key_set_t key_reg;
    sbe_pkg::key_set_t key_next;

    // Always able to take a register write
    assign cfg_ready = 1'b1;

    // Decode the index; drop writes past the last key
    always_comb
    begin
        key_next = key_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (sbe_pkg::reg_index_t'(cfg_index))
                sbe_pkg::REG_KEY_ONE:   key_next[0] = cfg_data;
                sbe_pkg::REG_KEY_TWO:   key_next[1] = cfg_data;
                sbe_pkg::REG_KEY_THREE: key_next[2] = cfg_data;
                sbe_pkg::REG_KEY_FOUR:  key_next[3] = cfg_data;
                sbe_pkg::REG_KEY_FIVE:  key_next[4] = cfg_data;
                default:                key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign keys = key_reg;

endmodule

// ===== src/sbe_round.sv =====
module sbe_round (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbe_pkg::stage_ctrl_t  in_ctrl,
    input  sbe_pkg::word_t        in_ol,
    input  sbe_pkg::word_t        in_il,
    input  sbe_pkg::word_t        in_ir,
    input  sbe_pkg::word_t        in_or,
    input  sbe_pkg::word_t        key,
    output sbe_pkg::stage_ctrl_t  out_ctrl,
    output sbe_pkg::word_t        out_ol,
    output sbe_pkg::word_t        out_il,
    output sbe_pkg::word_t        out_ir,
    output sbe_pkg::word_t        out_or
);

    sbe_pkg::stage_ctrl_t ctrl_reg;
    sbe_pkg::word_t       ol_reg, il_reg, ir_reg, or_reg;
    sbe_pkg::word_t       ol_next, il_next, ir_next, or_next;

    // Key the outer words, run them through F and fold into the opposite inner word
    always_comb
    begin
        ol_next = ~(in_ol ^ key);
        or_next = ~(in_or ^ key);
        il_next = sbe_pkg::mix_f(ol_next) ^ in_ir;
        ir_next = sbe_pkg::mix_f(or_next) ^ in_il;
    end

    // Advance the valid bit every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= in_ctrl;
        end
    end

    // Capture the round output
    always_ff @(posedge clk)
    begin
        ol_reg <= ol_next;
        il_reg <= il_next;
        ir_reg <= ir_next;
        or_reg <= or_next;
    end

    assign out_ctrl = ctrl_reg;
    assign out_ol   = ol_reg;
    assign out_il   = il_reg;
    assign out_ir   = ir_reg;
    assign out_or   = or_reg;

endmodule

// ===== src/sit_block_encrypt_top.sv =====
// Five-round 64-bit block encryption, one round per pipeline stage.
// A block transferred at a start edge shows on cipher_block with done after it
// has passed one input register and five round stages.
// Throughput: one block per cycle; busy is low in every cycle after the first.
// Reset (rst_n low, asynchronous): keys clear to zero, all stages empty, busy
// high for the first cycle after release. The receiver cannot stall done.
module sit_block_encrypt_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [sbe_pkg::BLOCK_W-1:0]    plain_block,
    output logic                           done,
    output logic [sbe_pkg::BLOCK_W-1:0]    cipher_block,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sbe_pkg::KEY_IDX_W-1:0]  cfg_index,
    input  logic [sbe_pkg::WORD_W-1:0]     cfg_data
);

    localparam int W = sbe_pkg::WORD_W;

    logic                  busy_reg, busy_next;
    sbe_pkg::stage_ctrl_t  in_ctrl_reg, in_ctrl_next;
    sbe_pkg::block_t       in_blk_reg;
    sbe_pkg::key_set_t     keys;

    sbe_pkg::stage_ctrl_t  ctrl [sbe_pkg::NUM_ROUNDS];
    sbe_pkg::word_t        w1 [sbe_pkg::NUM_ROUNDS];
    sbe_pkg::word_t        w2 [sbe_pkg::NUM_ROUNDS];
    sbe_pkg::word_t        w3 [sbe_pkg::NUM_ROUNDS];
    sbe_pkg::word_t        w4 [sbe_pkg::NUM_ROUNDS];

    // Hold busy for one cycle out of reset, then drop it for good
    assign busy_next = 1'b0;
    assign in_ctrl_next.valid = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            in_ctrl_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            in_ctrl_reg <= in_ctrl_next;
        end
    end

    // Register the plaintext on each transfer
    always_ff @(posedge clk)
    begin
        if (in_ctrl_next.valid)
        begin
            in_blk_reg <= plain_block;
        end
    end

    assign busy = busy_reg;

    sbe_key_regs u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keys      (keys)
    );

    // Round one: (w1, w2, w3, w4)
    sbe_round u_round1 (
        .clk (clk), .rst_n (rst_n),
        .in_ctrl (in_ctrl_reg),
        .in_ol (in_blk_reg[W-1:0]),     .in_il (in_blk_reg[2*W-1:W]),
        .in_ir (in_blk_reg[3*W-1:2*W]), .in_or (in_blk_reg[4*W-1:3*W]),
        .key (keys[0]),
        .out_ctrl (ctrl[0]),
        .out_ol (w1[0]), .out_il (w2[0]), .out_ir (w3[0]), .out_or (w4[0])
    );

    // Round two: roles swap to (w2, w1, w4, w3)
    sbe_round u_round2 (
        .clk (clk), .rst_n (rst_n),
        .in_ctrl (ctrl[0]),
        .in_ol (w2[0]), .in_il (w1[0]), .in_ir (w4[0]), .in_or (w3[0]),
        .key (keys[1]),
        .out_ctrl (ctrl[1]),
        .out_ol (w2[1]), .out_il (w1[1]), .out_ir (w4[1]), .out_or (w3[1])
    );

    // Round three
    sbe_round u_round3 (
        .clk (clk), .rst_n (rst_n),
        .in_ctrl (ctrl[1]),
        .in_ol (w1[1]), .in_il (w2[1]), .in_ir (w3[1]), .in_or (w4[1]),
        .key (keys[2]),
        .out_ctrl (ctrl[2]),
        .out_ol (w1[2]), .out_il (w2[2]), .out_ir (w3[2]), .out_or (w4[2])
    );

    // Round four: swapped roles
    sbe_round u_round4 (
        .clk (clk), .rst_n (rst_n),
        .in_ctrl (ctrl[2]),
        .in_ol (w2[2]), .in_il (w1[2]), .in_ir (w4[2]), .in_or (w3[2]),
        .key (keys[3]),
        .out_ctrl (ctrl[3]),
        .out_ol (w2[3]), .out_il (w1[3]), .out_ir (w4[3]), .out_or (w3[3])
    );

    // Round five
    sbe_round u_round5 (
        .clk (clk), .rst_n (rst_n),
        .in_ctrl (ctrl[3]),
        .in_ol (w1[3]), .in_il (w2[3]), .in_ir (w3[3]), .in_or (w4[3]),
        .key (keys[4]),
        .out_ctrl (ctrl[4]),
        .out_ol (w1[4]), .out_il (w2[4]), .out_ir (w3[4]), .out_or (w4[4])
    );

    // Present the last stage as the result
    assign done         = ctrl[4].valid;
    assign cipher_block = {w4[4], w3[4], w2[4], w1[4]};

endmodule

// ===== src/sbe_checker.sv =====
`include "sit_block_encrypt_top_defines.svh"

module sbe_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [sbe_pkg::BLOCK_W-1:0]    cipher_block,
    input logic                           cfg_ready
);

    logic in_xfer;

    assign in_xfer = start && !busy;

    // Every input transfer yields a result on done
    `SBE_ASSERT_IMPL(a_xfer_gives_done, clk, rst_n, in_xfer, ##6 done)

    // No result appears without an earlier input transfer
    `SBE_ASSERT_IMPL(a_done_has_xfer, clk, rst_n, done, $past(in_xfer, 6))

    // Once busy drops after reset it stays low
    `SBE_ASSERT_IMPL(a_busy_stays_low, clk, rst_n, !busy, ##1 !busy)

    // A result transfer always carries a known ciphertext
    `SBE_ASSERT_IMPL(a_done_known, clk, rst_n, done, !$isunknown(cipher_block))

    // The key port never holds off a write
    `SBE_ASSERT_ALWAYS(a_cfg_always_ready, clk, rst_n, cfg_ready)

endmodule

bind sit_block_encrypt_top sbe_checker u_sbe_checker (.*);
